/* design/itt_pkg.sv */
// ----------------------------------------------------------------------------
// INI text tokenizer package
// Shared constants, byte classes, roles and the queue item type.
// ----------------------------------------------------------------------------
package itt_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH           = 2;
   localparam int QUEUE_PTR_BITS        = $clog2(QUEUE_DEPTH);
   localparam int LENGTH_BITS           = 16;

   localparam logic [7:0] CHAR_NUL     = 8'd0;
   localparam logic [7:0] CHAR_HT      = 8'd9;
   localparam logic [7:0] CHAR_LF      = 8'd10;
   localparam logic [7:0] CHAR_CR      = 8'd13;
   localparam logic [7:0] CHAR_SP      = 8'd32;
   localparam logic [7:0] CHAR_HASH    = 8'd35;
   localparam logic [7:0] CHAR_SEMI    = 8'd59;
   localparam logic [7:0] CHAR_EQUALS  = 8'd61;
   localparam logic [7:0] CHAR_LBRACK  = 8'd91;
   localparam logic [7:0] CHAR_RBRACK  = 8'd93;

   typedef enum logic [2:0] {
      CLS_ZERO    = 3'd0,
      CLS_BREAK   = 3'd1,
      CLS_SPACE   = 3'd2,
      CLS_COMMENT = 3'd3,
      CLS_OPEN    = 3'd4,
      CLS_CLOSE   = 3'd5,
      CLS_EQUALS  = 3'd6,
      CLS_OTHER   = 3'd7
   } byte_class_type;

   typedef struct packed {
      byte_class_type cls;
      logic           eot;
   } queue_item_type;

   typedef enum logic [3:0] {
      ROLE_BLANK        = 4'd0,
      ROLE_COMMENT_MARK = 4'd1,
      ROLE_COMMENT_TEXT = 4'd2,
      ROLE_OPEN         = 4'd3,
      ROLE_SECTION_CHAR = 4'd4,
      ROLE_CLOSE        = 4'd5,
      ROLE_TAIL         = 4'd6,
      ROLE_NAME_CHAR    = 4'd7,
      ROLE_EQUALS       = 4'd8,
      ROLE_VALUE_CHAR   = 4'd9,
      ROLE_TERMINATOR   = 4'd10,
      ROLE_DISCARDED    = 4'd11
   } byte_role_type;

   typedef enum logic [1:0] {
      COMMIT_NONE    = 2'd0,
      COMMIT_SECTION = 2'd1,
      COMMIT_PAIR    = 2'd2
   } commit_kind_type;

   typedef enum logic [5:0] {
      MODE_FRESH   = 6'b000001,
      MODE_COMMENT = 6'b000010,
      MODE_SECT    = 6'b000100,
      MODE_TAIL    = 6'b001000,
      MODE_NAME    = 6'b010000,
      MODE_VALUE   = 6'b100000
   } parse_mode_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

/* design/ini_text_tokenizer.sv */
// ----------------------------------------------------------------------------
// INI text tokenizer
// Byte-serial INI classifier with line commits, error halt and length report.
// ----------------------------------------------------------------------------
// Each request carries one byte of INI text and returns exactly one response
// with the byte's role, a commit flag for completed section and name=value
// lines, an error flag, and on the last byte the text length or the offset of
// the failing line. The block sustains one request per clock while rsp_stall
// is low: the front end classifies the byte in the cycle it is accepted, a
// two-entry queue carries it to the parser, and the parser's state update
// loads the response register, so a byte passes the queue entry and then the
// response register. The queue lets requests keep arriving while a response
// is held by rsp_stall, until the queue fills.
module ini_text_tokenizer #(
   parameter int POSITION_BITS = itt_pkg::POSITION_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_byte_role,
   output logic [1:0]  rsp_commit_kind,
   output logic        rsp_parse_error,
   output logic        rsp_text_done,
   output logic [15:0] rsp_good_length
);

   itt_pkg::queue_status_type q_status;
   itt_pkg::queue_item_type   push_item;
   itt_pkg::queue_item_type   pop_item;
   logic                      push;
   logic                      pop;

   itt_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .q_status        (q_status),
      .push            (push),
      .push_item       (push_item)
   );

   itt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   itt_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .pop_item        (pop_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_byte_role   (rsp_byte_role),
      .rsp_commit_kind (rsp_commit_kind),
      .rsp_parse_error (rsp_parse_error),
      .rsp_text_done   (rsp_text_done),
      .rsp_good_length (rsp_good_length)
   );

endmodule

/* design/itt_front.sv */
// ----------------------------------------------------------------------------
// INI text tokenizer front end
// Accepts requests and sorts each byte into a small class for the back end.
// ----------------------------------------------------------------------------
module itt_front (
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_text_byte,
   input  logic                   req_end_of_text,
   input  itt_pkg::queue_status_type q_status,
   output logic                   push,
   output itt_pkg::queue_item_type push_item
);

   itt_pkg::byte_class_type cls;

   always_comb begin
      unique case (req_text_byte)
         itt_pkg::CHAR_NUL:                        cls = itt_pkg::CLS_ZERO;
         itt_pkg::CHAR_CR, itt_pkg::CHAR_LF:       cls = itt_pkg::CLS_BREAK;
         itt_pkg::CHAR_SP, itt_pkg::CHAR_HT:       cls = itt_pkg::CLS_SPACE;
         itt_pkg::CHAR_HASH, itt_pkg::CHAR_SEMI:   cls = itt_pkg::CLS_COMMENT;
         itt_pkg::CHAR_LBRACK:                     cls = itt_pkg::CLS_OPEN;
         itt_pkg::CHAR_RBRACK:                     cls = itt_pkg::CLS_CLOSE;
         itt_pkg::CHAR_EQUALS:                     cls = itt_pkg::CLS_EQUALS;
         default:                                  cls = itt_pkg::CLS_OTHER;
      endcase
   end

   assign req_stall     = q_status.full;
   assign push          = req_valid && !q_status.full;
   assign push_item.cls = cls;
   assign push_item.eot = req_end_of_text;

endmodule

/* design/itt_queue.sv */
// ----------------------------------------------------------------------------
// INI text tokenizer queue
// Short FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module itt_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  itt_pkg::queue_item_type   push_item,
   input  logic                      pop,
   output itt_pkg::queue_item_type   pop_item,
   output itt_pkg::queue_status_type status
);

   localparam int PB = itt_pkg::QUEUE_PTR_BITS;
   localparam int CB = $clog2(itt_pkg::QUEUE_DEPTH + 1);

   itt_pkg::queue_item_type entry_ff [itt_pkg::QUEUE_DEPTH];
   logic [PB-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CB-1:0] count_ff, count_in;

   function automatic logic [PB-1:0] ptr_next(input logic [PB-1:0] p);
      return (p == PB'(itt_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PB'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CB'(push) - CB'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item         = entry_ff[rd_ptr_ff];
   assign status.full      = (count_ff == CB'(itt_pkg::QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);

endmodule

/* design/itt_back.sv */
// ----------------------------------------------------------------------------
// INI text tokenizer back end
// Runs the line parser on classified bytes and holds the response register.
// ----------------------------------------------------------------------------
module itt_back #(
   parameter int POSITION_BITS = itt_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  itt_pkg::queue_status_type q_status,
   input  itt_pkg::queue_item_type   pop_item,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [3:0]                rsp_byte_role,
   output logic [1:0]                rsp_commit_kind,
   output logic                      rsp_parse_error,
   output logic                      rsp_text_done,
   output logic [15:0]               rsp_good_length
);

   localparam int LB = itt_pkg::LENGTH_BITS;

   itt_pkg::parse_mode_type  mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] lso_ff, lso_in;
   logic                     halt_ff, halt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   itt_pkg::byte_role_type   role_ff, role_in;
   itt_pkg::commit_kind_type commit_ff, commit_in;
   logic                     err_ff, err_in;
   logic                     done_ff, done_in;
   logic [LB-1:0]            len_ff, len_in;

   logic                     is_zero, is_brk, end_check;
   logic [POSITION_BITS-1:0] len_full;

   // The response register frees up when empty or when its response is taken.
   assign pop = q_status.not_empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      lso_in    = lso_ff;
      halt_in   = halt_ff;
      role_in   = itt_pkg::ROLE_BLANK;
      commit_in = itt_pkg::COMMIT_NONE;
      err_in    = 1'b0;
      end_check = 1'b0;
      is_zero   = (pop_item.cls == itt_pkg::CLS_ZERO);
      is_brk    = (pop_item.cls == itt_pkg::CLS_BREAK);
      done_in   = is_zero || pop_item.eot;

      if (is_zero) begin
         role_in   = itt_pkg::ROLE_TERMINATOR;
         end_check = !halt_ff;
      end else if (halt_ff) begin
         role_in = itt_pkg::ROLE_DISCARDED;
      end else begin
         unique case (mode_ff)
            itt_pkg::MODE_COMMENT: begin
               if (is_brk) begin
                  role_in = itt_pkg::ROLE_BLANK;
                  mode_in = itt_pkg::MODE_FRESH;
               end else begin
                  role_in = itt_pkg::ROLE_COMMENT_TEXT;
               end
            end
            itt_pkg::MODE_SECT: begin
               if (is_brk) begin
                  role_in = itt_pkg::ROLE_DISCARDED;
                  err_in  = 1'b1;
                  halt_in = 1'b1;
               end else if (pop_item.cls == itt_pkg::CLS_CLOSE) begin
                  role_in = itt_pkg::ROLE_CLOSE;
                  mode_in = itt_pkg::MODE_TAIL;
               end else begin
                  role_in = itt_pkg::ROLE_SECTION_CHAR;
               end
            end
            itt_pkg::MODE_TAIL: begin
               if (is_brk) begin
                  commit_in = itt_pkg::COMMIT_SECTION;
                  mode_in   = itt_pkg::MODE_FRESH;
               end else begin
                  role_in = itt_pkg::ROLE_TAIL;
               end
            end
            itt_pkg::MODE_NAME: begin
               if (is_brk) begin
                  role_in = itt_pkg::ROLE_DISCARDED;
                  err_in  = 1'b1;
                  halt_in = 1'b1;
               end else if (pop_item.cls == itt_pkg::CLS_EQUALS) begin
                  role_in = itt_pkg::ROLE_EQUALS;
                  mode_in = itt_pkg::MODE_VALUE;
               end else begin
                  role_in = itt_pkg::ROLE_NAME_CHAR;
               end
            end
            itt_pkg::MODE_VALUE: begin
               if (is_brk) begin
                  commit_in = itt_pkg::COMMIT_PAIR;
                  mode_in   = itt_pkg::MODE_FRESH;
               end else begin
                  role_in = itt_pkg::ROLE_VALUE_CHAR;
               end
            end
            default: begin
               if (!is_brk && pop_item.cls != itt_pkg::CLS_SPACE) begin
                  lso_in = pos_ff;
                  case (pop_item.cls)
                     itt_pkg::CLS_COMMENT: begin
                        role_in = itt_pkg::ROLE_COMMENT_MARK;
                        mode_in = itt_pkg::MODE_COMMENT;
                     end
                     itt_pkg::CLS_OPEN: begin
                        role_in = itt_pkg::ROLE_OPEN;
                        mode_in = itt_pkg::MODE_SECT;
                     end
                     itt_pkg::CLS_EQUALS: begin
                        role_in = itt_pkg::ROLE_EQUALS;
                        mode_in = itt_pkg::MODE_VALUE;
                     end
                     default: begin
                        role_in = itt_pkg::ROLE_NAME_CHAR;
                        mode_in = itt_pkg::MODE_NAME;
                     end
                  endcase
               end
            end
         endcase
         end_check = pop_item.eot && !halt_in;
      end

      if (!is_zero && pos_ff != '1) begin
         pos_in = pos_ff + POSITION_BITS'(1);
      end

      // An open section or name line at the end of the text fails the line; a section tail or value line is committed.
      if (end_check) begin
         if (mode_in == itt_pkg::MODE_SECT || mode_in == itt_pkg::MODE_NAME) begin
            err_in  = 1'b1;
            halt_in = 1'b1;
         end else if (mode_in == itt_pkg::MODE_TAIL) begin
            commit_in = itt_pkg::COMMIT_SECTION;
         end else if (mode_in == itt_pkg::MODE_VALUE) begin
            commit_in = itt_pkg::COMMIT_PAIR;
         end
      end

      len_full = halt_in ? lso_in : pos_in;
      len_in   = '0;
      if (done_in) begin
         if ((POSITION_BITS > LB) && (len_full > POSITION_BITS'({LB{1'b1}}))) begin
            len_in = '1;
         end else begin
            len_in = LB'(len_full);
         end
         mode_in = itt_pkg::MODE_FRESH;
         pos_in  = '0;
         lso_in  = '0;
         halt_in = 1'b0;
      end

      rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= itt_pkg::MODE_FRESH;
         pos_ff       <= '0;
         lso_ff       <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            mode_ff <= mode_in;
            pos_ff  <= pos_in;
            lso_ff  <= lso_in;
            halt_ff <= halt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         role_ff   <= role_in;
         commit_ff <= commit_in;
         err_ff    <= err_in;
         done_ff   <= done_in;
         len_ff    <= len_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_role   = role_ff;
   assign rsp_commit_kind = commit_ff;
   assign rsp_parse_error = err_ff;
   assign rsp_text_done   = done_ff;
   assign rsp_good_length = len_ff;

endmodule
